// ----- hw/rtl/bcse_pkg.sv -----
// package for the bcd clock set editor: transfer structs, key codes and digit helpers
// no dependencies; imported by every module of the block
package bcse_pkg;

	// opcode values of an input transfer
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_KEY    = 1'b1;

	// key codes
	localparam logic [7:0] KEY_UP     = 8'h26;
	localparam logic [7:0] KEY_DOWN   = 8'h28;
	localparam logic [7:0] KEY_LEFT   = 8'h25;
	localparam logic [7:0] KEY_RIGHT  = 8'h27;
	localparam logic [7:0] KEY_ENTER  = 8'h0D;
	localparam logic [7:0] KEY_ESCAPE = 8'h1B;

	// digit positions and bcd limits
	localparam int unsigned BYTE_COUNT  = 6;
	localparam logic [3:0]  DIGIT_COUNT = 4'd12;
	localparam logic [3:0]  POS_IDLE    = 4'd0;
	localparam logic [3:0]  POS_FIRST   = 4'd1;
	localparam logic [3:0]  NIBBLE_MAX  = 4'd9;

	// one input transfer
	typedef struct packed {
		logic       opcode;
		logic [7:0] key_code;
		logic [7:0] in_year;
		logic [7:0] in_month;
		logic [7:0] in_day;
		logic [7:0] in_hour;
		logic [7:0] in_minute;
		logic [7:0] in_second;
	} req_t;

	// one result transfer
	typedef struct packed {
		logic       editing;
		logic [3:0] digit_position;
		logic       save_strobe;
		logic [7:0] out_year;
		logic [7:0] out_month;
		logic [7:0] out_day;
		logic [7:0] out_hour;
		logic [7:0] out_minute;
		logic [7:0] out_second;
	} rsp_t;

	// editor state: byte 0 is year, byte 5 is second
	typedef struct packed {
		logic [3:0]                       pos;
		logic [BYTE_COUNT-1:0][7:0]       bytes;
	} state_t;

	// step one bcd nibble up or down with wraparound; a non-bcd nibble goes to 0 on up
	function automatic logic [3:0] step_nibble(input logic [3:0] nib, input logic up);
		logic [3:0] res;
		if (up) begin
			res = (nib < NIBBLE_MAX) ? nib + 4'd1 : 4'd0;
		end else begin
			res = (nib != 4'd0) ? nib - 4'd1 : NIBBLE_MAX;
		end
		return res;
	endfunction

endpackage

// ----- hw/rtl/bcse_update.sv -----
// next-state and result logic of the bcd clock set editor for one input transfer
// depends on bcse_pkg
module bcse_update (
	input  bcse_pkg::req_t   item,
	input  bcse_pkg::state_t cur,
	output bcse_pkg::state_t nxt,
	output bcse_pkg::rsp_t   res
);
	import bcse_pkg::*;

	logic       save;
	logic       pos_valid;
	logic [3:0] pos_m1;
	logic [2:0] sel_byte;
	logic       sel_high;

	// decode the selected byte and nibble from the digit position
	assign pos_valid = (cur.pos >= POS_FIRST) && (cur.pos <= DIGIT_COUNT);
	assign pos_m1    = cur.pos - 4'd1;
	assign sel_byte  = pos_m1[3:1];
	assign sel_high  = ~pos_m1[0];

	// state update for samples and keys
	always_comb begin
		nxt  = cur;
		save = 1'b0;
		if (item.opcode == OP_SAMPLE) begin
			if (cur.pos == POS_IDLE) begin
				nxt.bytes[0] = item.in_year;
				nxt.bytes[1] = item.in_month;
				nxt.bytes[2] = item.in_day;
				nxt.bytes[3] = item.in_hour;
				nxt.bytes[4] = item.in_minute;
				nxt.bytes[5] = item.in_second;
			end
		end else begin
			case (item.key_code)
				KEY_UP, KEY_DOWN: begin
					for (int k = 0; k < BYTE_COUNT; k++) begin
						if (pos_valid && sel_byte == 3'(k)) begin
							if (sel_high) begin
								nxt.bytes[k][7:4] = step_nibble(cur.bytes[k][7:4],
									item.key_code == KEY_UP);
							end else begin
								nxt.bytes[k][3:0] = step_nibble(cur.bytes[k][3:0],
									item.key_code == KEY_UP);
							end
						end
					end
				end
				KEY_LEFT: begin
					if (cur.pos != POS_IDLE) begin
						nxt.pos = (cur.pos > POS_FIRST) ? cur.pos - 4'd1 : DIGIT_COUNT;
					end
				end
				KEY_RIGHT: begin
					if (cur.pos != POS_IDLE) begin
						nxt.pos = (cur.pos < DIGIT_COUNT) ? cur.pos + 4'd1 : POS_FIRST;
					end
				end
				KEY_ENTER: begin
					if (cur.pos == POS_IDLE) begin
						nxt.pos = POS_FIRST;
					end else begin
						nxt.pos = POS_IDLE;
						save    = 1'b1;
					end
				end
				KEY_ESCAPE: begin
					nxt.pos = POS_IDLE;
				end
				default: begin
					nxt = cur;
				end
			endcase
		end
	end

	// result reflects the state after the update
	always_comb begin
		res.editing        = (nxt.pos != POS_IDLE);
		res.digit_position = nxt.pos;
		res.save_strobe    = save;
		res.out_year       = nxt.bytes[0];
		res.out_month      = nxt.bytes[1];
		res.out_day        = nxt.bytes[2];
		res.out_hour       = nxt.bytes[3];
		res.out_minute     = nxt.bytes[4];
		res.out_second     = nxt.bytes[5];
	end

endmodule

// ----- hw/rtl/bcd_clock_set_editor.sv -----
// A transfer is taken into the input register, and its result is captured in the result register
// as it leaves stage 1; a stalled result register can hold it in stage 1 in between.
// Throughput: one transfer per cycle while no stalled result holds stage 1; the state update
// sits between the input and result registers, so each item sees the state the previous one left.
// Reset (arst_n low, asynchronous): both stages empty, not editing, time buffer all zero.
// depends on bcse_pkg and bcse_update
module bcd_clock_set_editor (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  bcse_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output bcse_pkg::rsp_t  rsp
);
	import bcse_pkg::*;

	logic     valid_s1;
	req_t     item_s1;
	state_t   state_q;
	state_t   state_nxt;
	rsp_t     res;
	rsp_t     rsp_q;
	logic     rsp_valid_q;
	logic     advance;

	// stage 1 moves on when the result register is free or being taken
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			item_s1 <= req;
		end
	end

	bcse_update u_update (
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res)
	);

	// editor state, committed as the item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- hw/rtl/bcse_checker.sv -----
// port-level checks for the bcd clock set editor, bound to the top level
// depends on bcse_pkg and bcd_clock_set_editor
module bcse_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_stall,
	input  bcse_pkg::req_t  req,
	input  logic            rsp_valid,
	input  logic            rsp_stall,
	input  bcse_pkg::rsp_t  rsp
);
	import bcse_pkg::*;

	// editing flag agrees with the digit position
	a_edit_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.editing == (rsp.digit_position != POS_IDLE)))
		else $error("editing flag disagrees with digit position");

	// digit position never leaves 0..12
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.digit_position <= DIGIT_COUNT))
		else $error("digit position out of range");

	// a save always leaves editing
	a_save_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.save_strobe) |-> !rsp.editing)
		else $error("save strobe while still editing");

	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled result changed");

	// a stalled request holds
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_stall) |=> (req_valid && $stable(req)))
		else $error("stalled request changed");

endmodule

bind bcd_clock_set_editor bcse_checker u_bcse_checker (.*);
